### hw/rtl/jsu_pkg.sv
// Shared types, codes and helper functions of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;

	// Input byte values that steer decoding
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_U         = 8'h75;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_STR    = 3'd1,
		MODE_ESC    = 3'd2,
		MODE_HEX    = 3'd3,
		MODE_LOWBS  = 3'd4,
		MODE_LOWU   = 3'd5,
		MODE_LOWHEX = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE          = 4'd0,
		ERR_UNTERMINATED  = 4'd1,
		ERR_TRUNC_ESCAPE  = 4'd2,
		ERR_BAD_ESCAPE    = 4'd3,
		ERR_BAD_HEX       = 4'd4,
		ERR_TRUNC_U       = 4'd5,
		ERR_MISSING_LOW   = 4'd6,
		ERR_INVALID_LOW   = 4'd7,
		ERR_UNEXPECTED_LO = 4'd8,
		ERR_NO_OPEN_QUOTE = 4'd9
	} err_t;

	// One classified item: nb results to emit (0 = none). For a byte result
	// nb of 1 sends cp[7:0] as is, 2..4 encodes cp as UTF-8.
	typedef struct packed {
		kind_t       kind;
		err_t        err;
		logic [20:0] cp;
		logic [2:0]  nb;
	} entry_t;

	// Returns {ok, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// Returns {ok, decoded byte}
	function automatic logic [8:0] simple_escape(input logic [7:0] e);
		logic [8:0] r;
		unique case (e)
			8'h22:   r = {1'b1, 8'h22};
			8'h5C:   r = {1'b1, 8'h5C};
			8'h2F:   r = {1'b1, 8'h2F};
			8'h62:   r = {1'b1, 8'h08};
			8'h66:   r = {1'b1, 8'h0C};
			8'h6E:   r = {1'b1, 8'h0A};
			8'h72:   r = {1'b1, 8'h0D};
			8'h74:   r = {1'b1, 8'h09};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Byte idx of the nb-byte UTF-8 form of cp
	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] nb,
			input logic [1:0] idx);
		logic [7:0] b;
		unique case (nb)
			3'd2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			3'd3: begin
				unique case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd4: begin
				unique case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = cp[7:0];
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/jsu_if.sv
// Valid/ready channel interfaces for raw text bytes and decoded results.
`default_nettype none
interface jsu_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source(output valid, in_byte, end_of_input, input ready);
	modport sink(input valid, in_byte, end_of_input, output ready);
endinterface

interface jsu_dec_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] result_kind;
	logic [3:0] error_code;
	logic       last;

	modport source(output valid, out_byte, result_kind, error_code, last, input ready);
	modport sink(input valid, out_byte, result_kind, error_code, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/jsu_front.sv
// Front end: runs the escape decoder on each byte and classifies its results.
`default_nettype none
module jsu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid,
	input  wire logic          ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          end_of_input,
	output jsu_pkg::entry_t    entry,
	output logic               push
);

	jsu_pkg::mode_t mode_q, mode_d;
	logic [15:0]    acc_q, acc_d;
	logic [1:0]     cnt_q, cnt_d;
	logic [9:0]     hs_q, hs_d;

	logic        accept;
	logic [4:0]  hex;
	logic [8:0]  esc;
	logic [15:0] acc_next;
	logic        digits_done;
	logic        is_high;
	logic        is_low;
	logic [20:0] pair_cp;

	assign accept      = valid && ready;
	assign hex         = jsu_pkg::hex_value(in_byte);
	assign esc         = jsu_pkg::simple_escape(in_byte);
	assign acc_next    = {acc_q[11:0], hex[3:0]};
	assign digits_done = (cnt_q == 2'd3);
	assign is_high     = (acc_next[15:10] == 6'b110110);
	assign is_low      = (acc_next[15:10] == 6'b110111);
	assign pair_cp     = 21'h10000 + {1'b0, hs_q, acc_next[9:0]};

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		cnt_d  = cnt_q;
		hs_d   = hs_q;
		unique case (mode_q)
			jsu_pkg::MODE_STR: begin
				if (end_of_input || in_byte == jsu_pkg::CH_QUOTE) begin
					mode_d = jsu_pkg::MODE_IDLE;
				end else if (in_byte == jsu_pkg::CH_BACKSLASH) begin
					mode_d = jsu_pkg::MODE_ESC;
				end
			end
			jsu_pkg::MODE_ESC: begin
				if (end_of_input) begin
					mode_d = jsu_pkg::MODE_IDLE;
				end else if (in_byte == jsu_pkg::CH_U) begin
					mode_d = jsu_pkg::MODE_HEX;
					acc_d  = '0;
					cnt_d  = '0;
				end else if (esc[8]) begin
					mode_d = jsu_pkg::MODE_STR;
				end else begin
					mode_d = jsu_pkg::MODE_IDLE;
				end
			end
			jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOWHEX: begin
				if (end_of_input || !hex[4]) begin
					mode_d = jsu_pkg::MODE_IDLE;
				end else if (!digits_done) begin
					acc_d = acc_next;
					cnt_d = cnt_q + 2'd1;
				end else begin
					acc_d = '0;
					cnt_d = '0;
					if (mode_q == jsu_pkg::MODE_HEX) begin
						if (is_high) begin
							hs_d   = acc_next[9:0];
							mode_d = jsu_pkg::MODE_LOWBS;
						end else if (is_low) begin
							mode_d = jsu_pkg::MODE_IDLE;
						end else begin
							mode_d = jsu_pkg::MODE_STR;
						end
					end else if (is_low) begin
						hs_d   = '0;
						mode_d = jsu_pkg::MODE_STR;
					end else begin
						mode_d = jsu_pkg::MODE_IDLE;
					end
				end
			end
			jsu_pkg::MODE_LOWBS: begin
				mode_d = (end_of_input || in_byte != jsu_pkg::CH_BACKSLASH) ?
					jsu_pkg::MODE_IDLE : jsu_pkg::MODE_LOWU;
			end
			jsu_pkg::MODE_LOWU: begin
				if (end_of_input || in_byte != jsu_pkg::CH_U) begin
					mode_d = jsu_pkg::MODE_IDLE;
				end else begin
					mode_d = jsu_pkg::MODE_LOWHEX;
					acc_d  = '0;
					cnt_d  = '0;
				end
			end
			default: begin
				mode_d = (end_of_input || in_byte != jsu_pkg::CH_QUOTE) ?
					jsu_pkg::MODE_IDLE : jsu_pkg::MODE_STR;
			end
		endcase
		// every return to idle drops the escape context
		if (mode_d == jsu_pkg::MODE_IDLE) begin
			acc_d = '0;
			cnt_d = '0;
			hs_d  = '0;
		end
	end

	always_comb begin
		entry.kind = jsu_pkg::KIND_BYTE;
		entry.err  = jsu_pkg::ERR_NONE;
		entry.cp   = '0;
		entry.nb   = 3'd0;
		unique case (mode_q)
			jsu_pkg::MODE_STR: begin
				if (end_of_input) begin
					entry.kind = jsu_pkg::KIND_ERROR;
					entry.err  = jsu_pkg::ERR_UNTERMINATED;
					entry.nb   = 3'd1;
				end else if (in_byte == jsu_pkg::CH_QUOTE) begin
					entry.kind = jsu_pkg::KIND_CLOSE;
					entry.nb   = 3'd1;
				end else if (in_byte != jsu_pkg::CH_BACKSLASH) begin
					entry.cp = {13'd0, in_byte};
					entry.nb = 3'd1;
				end
			end
			jsu_pkg::MODE_ESC: begin
				if (end_of_input) begin
					entry.kind = jsu_pkg::KIND_ERROR;
					entry.err  = jsu_pkg::ERR_TRUNC_ESCAPE;
					entry.nb   = 3'd1;
				end else if (in_byte == jsu_pkg::CH_U) begin
					entry.nb = 3'd0;
				end else if (esc[8]) begin
					entry.cp = {13'd0, esc[7:0]};
					entry.nb = 3'd1;
				end else begin
					entry.kind = jsu_pkg::KIND_ERROR;
					entry.err  = jsu_pkg::ERR_BAD_ESCAPE;
					entry.nb   = 3'd1;
				end
			end
			jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOWHEX: begin
				if (end_of_input) begin
					entry.kind = jsu_pkg::KIND_ERROR;
					entry.err  = jsu_pkg::ERR_TRUNC_U;
					entry.nb   = 3'd1;
				end else if (!hex[4]) begin
					entry.kind = jsu_pkg::KIND_ERROR;
					entry.err  = jsu_pkg::ERR_BAD_HEX;
					entry.nb   = 3'd1;
				end else if (digits_done) begin
					if (mode_q == jsu_pkg::MODE_HEX) begin
						if (is_low) begin
							entry.kind = jsu_pkg::KIND_ERROR;
							entry.err  = jsu_pkg::ERR_UNEXPECTED_LO;
							entry.nb   = 3'd1;
						end else if (!is_high) begin
							entry.cp = {5'd0, acc_next};
							if (acc_next[15:7] == 9'd0) begin
								entry.nb = 3'd1;
							end else if (acc_next[15:11] == 5'd0) begin
								entry.nb = 3'd2;
							end else begin
								entry.nb = 3'd3;
							end
						end
					end else if (is_low) begin
						entry.cp = pair_cp;
						entry.nb = 3'd4;
					end else begin
						entry.kind = jsu_pkg::KIND_ERROR;
						entry.err  = jsu_pkg::ERR_INVALID_LOW;
						entry.nb   = 3'd1;
					end
				end
			end
			jsu_pkg::MODE_LOWBS, jsu_pkg::MODE_LOWU: begin
				if (mode_d == jsu_pkg::MODE_IDLE) begin
					entry.kind = jsu_pkg::KIND_ERROR;
					entry.err  = jsu_pkg::ERR_MISSING_LOW;
					entry.nb   = 3'd1;
				end
			end
			default: begin
				if (end_of_input || in_byte != jsu_pkg::CH_QUOTE) begin
					entry.kind = jsu_pkg::KIND_ERROR;
					entry.err  = jsu_pkg::ERR_NO_OPEN_QUOTE;
					entry.nb   = 3'd1;
				end
			end
		endcase
	end

	assign push = accept && (entry.nb != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::MODE_IDLE;
			acc_q  <= '0;
			cnt_q  <= '0;
			hs_q   <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
			hs_q   <= hs_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/jsu_queue.sv
// Small FIFO of classified items between the front end and the emitter.
`default_nettype none
module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire jsu_pkg::entry_t  wr_entry,
	input  wire logic             pop,
	output jsu_pkg::entry_t       head,
	output logic                  not_empty,
	output logic                  full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/jsu_back.sv
// Back end: expands each queued item into its result bytes, one per cycle while the output is not stalled.
`default_nettype none
module jsu_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire jsu_pkg::entry_t  head,
	input  wire logic             not_empty,
	output logic                  pop,
	output logic                  valid,
	input  wire logic             ready,
	output logic [7:0]            out_byte,
	output logic [1:0]            result_kind,
	output logic [3:0]            error_code,
	output logic                  last
);

	jsu_pkg::entry_t cur_q;
	logic            cur_valid_q;
	logic [1:0]      idx_q;
	logic            out_valid_q;
	logic [7:0]      byte_q;
	logic [1:0]      kind_q;
	logic [3:0]      err_q;
	logic            last_q;

	logic load_out;
	logic finishing;

	assign load_out  = !out_valid_q || ready;
	assign finishing = ({1'b0, idx_q} + 3'd1 == cur_q.nb);
	assign pop       = not_empty && (!cur_valid_q || (load_out && finishing));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (load_out && cur_valid_q) begin
				if (finishing) begin
					cur_valid_q <= 1'b0;
				end
				idx_q <= idx_q + 2'd1;
			end
			if (load_out) begin
				out_valid_q <= cur_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (load_out && cur_valid_q) begin
			byte_q <= (cur_q.kind == jsu_pkg::KIND_BYTE) ?
				jsu_pkg::utf8_byte(cur_q.cp, cur_q.nb, idx_q) : 8'd0;
			kind_q <= cur_q.kind;
			err_q  <= cur_q.err;
			last_q <= finishing;
		end
	end

	assign valid       = out_valid_q;
	assign out_byte    = byte_q;
	assign result_kind = kind_q;
	assign error_code  = err_q;
	assign last        = last_q;

endmodule
`default_nettype wire

### hw/rtl/json_string_unescape_utf8.sv
// A byte's result passes the item queue, the back end's cur_q and its output registers.
// Throughput, while decoded.ready is held: one input byte per cycle when each byte gives
// at most one result; the back end emits a \u escape's 1 to 4 UTF-8 bytes one per cycle.
// The item queue (QUEUE_DEPTH entries) lets input continue during multi-byte output.
// Reset: arst_n clears decoder state to awaiting an opening quote and empties the queue.
`default_nettype none
module json_string_unescape_utf8 #(
	parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jsu_text_if.sink   text,
	jsu_dec_if.source  decoded
);

	jsu_pkg::entry_t entry;
	jsu_pkg::entry_t head;
	logic            push;
	logic            pop;
	logic            not_empty;
	logic            full;

	assign text.ready = !full;

	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (text.valid),
		.ready        (!full),
		.in_byte      (text.in_byte),
		.end_of_input (text.end_of_input),
		.entry        (entry),
		.push         (push)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (entry),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	jsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.not_empty   (not_empty),
		.pop         (pop),
		.valid       (decoded.valid),
		.ready       (decoded.ready),
		.out_byte    (decoded.out_byte),
		.result_kind (decoded.result_kind),
		.error_code  (decoded.error_code),
		.last        (decoded.last)
	);

endmodule
`default_nettype wire

### hw/rtl/jsu_checker.sv
// Port-level checks on the decoded result channel, bound to the top level.
`default_nettype none
module jsu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       valid,
	input wire logic       ready,
	input wire logic [7:0] out_byte,
	input wire logic [1:0] result_kind,
	input wire logic [3:0] error_code,
	input wire logic       last
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte) && $stable(result_kind) &&
			$stable(error_code) && $stable(last))
		else $error("stalled result changed");

	a_close_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind != jsu_pkg::KIND_BYTE |-> last)
		else $error("close or error item not marked last");

	a_code_only_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind != jsu_pkg::KIND_ERROR |-> error_code == jsu_pkg::ERR_NONE)
		else $error("error code on a non-error item");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind == jsu_pkg::KIND_ERROR |-> error_code != jsu_pkg::ERR_NONE &&
			out_byte == 8'd0)
		else $error("error item with bad fields");

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (decoded.valid),
	.ready       (decoded.ready),
	.out_byte    (decoded.out_byte),
	.result_kind (decoded.result_kind),
	.error_code  (decoded.error_code),
	.last        (decoded.last)
);
`default_nettype wire

### tb/sv/jsu_decode_board_pkg.sv
// Expected-result tracker for the JSON string unescaper: decoder copy plus result checks.
package jsu_decode_board_pkg;
	import jsu_pkg::*;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;

	typedef struct {
		logic [7:0] out_byte;
		kind_t      kind;
		err_t       err;
		logic       last;
	} dec_result_t;

	function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
			return 1'b1;
		end
		// letters: low nibble of 'a'..'f' and 'A'..'F' is 1..6
		if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = c[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit escape_value(input logic [7:0] c, output logic [7:0] v);
		bit ok;
		ok = 1'b1;
		case (c)
			8'h22:   v = 8'h22;  // quote
			8'h5C:   v = 8'h5C;  // backslash
			8'h2F:   v = 8'h2F;  // slash
			8'h62:   v = 8'h08;  // b
			8'h66:   v = 8'h0C;  // f
			8'h6E:   v = 8'h0A;  // n
			8'h72:   v = 8'h0D;  // r
			8'h74:   v = 8'h09;  // t
			default: begin
				v = 8'h00;
				ok = 1'b0;
			end
		endcase
		return ok;
	endfunction

	class utf8_decode_board;
		mode_t       mode;
		logic [15:0] accum;
		logic [1:0]  ndigits;
		logic [9:0]  high_bits;
		dec_result_t awaited[$];
		dec_result_t step_out[$];
		int          mismatches;
		int          checked;
		int          n_bytes;
		int          n_closes;
		int          n_errors;
		bit [15:0]   codes_seen;

		function new();
			restart();
		endfunction

		function void restart();
			mode = MODE_IDLE;
			accum = '0;
			ndigits = '0;
			high_bits = '0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void push(input logic [7:0] b, input kind_t k, input err_t e);
			dec_result_t r;
			r.out_byte = b;
			r.kind = k;
			r.err = e;
			r.last = 1'b0;
			step_out.insert(step_out.size(), r);
		endfunction

		function void fail_with(input err_t e);
			restart();
			push(8'h00, KIND_ERROR, e);
		endfunction

		function void push_utf8(input logic [20:0] cp);
			if (cp <= 21'h7F) begin
				push(cp[7:0], KIND_BYTE, ERR_NONE);
			end else if (cp <= 21'h7FF) begin
				push(8'hC0 | {3'b0, cp[10:6]}, KIND_BYTE, ERR_NONE);
				push(8'h80 | {2'b0, cp[5:0]}, KIND_BYTE, ERR_NONE);
			end else if (cp <= 21'hFFFF) begin
				push(8'hE0 | {4'b0, cp[15:12]}, KIND_BYTE, ERR_NONE);
				push(8'h80 | {2'b0, cp[11:6]}, KIND_BYTE, ERR_NONE);
				push(8'h80 | {2'b0, cp[5:0]}, KIND_BYTE, ERR_NONE);
			end else begin
				push(8'hF0 | {5'b0, cp[20:18]}, KIND_BYTE, ERR_NONE);
				push(8'h80 | {2'b0, cp[17:12]}, KIND_BYTE, ERR_NONE);
				push(8'h80 | {2'b0, cp[11:6]}, KIND_BYTE, ERR_NONE);
				push(8'h80 | {2'b0, cp[5:0]}, KIND_BYTE, ERR_NONE);
			end
		endfunction

		function void decode(input logic [7:0] c, input logic eoi);
			logic [3:0]  nib;
			logic [7:0]  esc;
			logic [15:0] code;
			logic [20:0] full;
			case (mode)
				MODE_STR: begin
					if (eoi) begin
						fail_with(ERR_UNTERMINATED);
					end else if (c == CH_QUOTE) begin
						restart();
						push(8'h00, KIND_CLOSE, ERR_NONE);
					end else if (c == CH_BACKSLASH) begin
						mode = MODE_ESC;
					end else begin
						push(c, KIND_BYTE, ERR_NONE);
					end
				end
				MODE_ESC: begin
					if (eoi) begin
						fail_with(ERR_TRUNC_ESCAPE);
					end else if (c == CH_U) begin
						mode = MODE_HEX;
						accum = '0;
						ndigits = '0;
					end else if (!escape_value(c, esc)) begin
						fail_with(ERR_BAD_ESCAPE);
					end else begin
						mode = MODE_STR;
						push(esc, KIND_BYTE, ERR_NONE);
					end
				end
				MODE_HEX, MODE_LOWHEX: begin
					if (eoi) begin
						fail_with(ERR_TRUNC_U);
					end else if (!hex_nibble(c, nib)) begin
						fail_with(ERR_BAD_HEX);
					end else begin
						accum = {accum[11:0], nib};
						if (ndigits != 2'd3) begin
							ndigits++;
						end else begin
							code = accum;
							accum = '0;
							ndigits = '0;
							if (mode == MODE_HEX) begin
								if (code >= HIGH_FIRST && code <= HIGH_LAST) begin
									// hold the high half until its partner arrives
									high_bits = code[9:0];
									mode = MODE_LOWBS;
								end else if (code >= LOW_FIRST && code <= LOW_LAST) begin
									fail_with(ERR_UNEXPECTED_LO);
								end else begin
									mode = MODE_STR;
									push_utf8({5'd0, code});
								end
							end else if (code < LOW_FIRST || code > LOW_LAST) begin
								fail_with(ERR_INVALID_LOW);
							end else begin
								full = 21'h10000 + {1'b0, high_bits, code[9:0]};
								high_bits = '0;
								mode = MODE_STR;
								push_utf8(full);
							end
						end
					end
				end
				MODE_LOWBS: begin
					if (eoi || c != CH_BACKSLASH) begin
						fail_with(ERR_MISSING_LOW);
					end else begin
						mode = MODE_LOWU;
					end
				end
				MODE_LOWU: begin
					if (eoi || c != CH_U) begin
						fail_with(ERR_MISSING_LOW);
					end else begin
						mode = MODE_LOWHEX;
						accum = '0;
						ndigits = '0;
					end
				end
				default: begin
					if (eoi || c != CH_QUOTE) begin
						fail_with(ERR_NO_OPEN_QUOTE);
					end else begin
						restart();
						mode = MODE_STR;
					end
				end
			endcase
		endfunction

		function void note_text(input logic [7:0] c, input logic eoi);
			step_out.delete();
			decode(c, eoi);
			if (step_out.size() > 0) begin
				step_out[step_out.size() - 1].last = 1'b1;
			end
			foreach (step_out[i]) begin
				awaited.insert(awaited.size(), step_out[i]);
			end
		endfunction

		function void report(input string field, input logic [7:0] want, input logic [7:0] got);
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			mismatches++;
		endfunction

		function void check_result(input logic [7:0] b, input logic [1:0] k, input logic [3:0] e,
				input logic l);
			dec_result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: extra result, expected none, got byte %0h kind %0d code %0d last %0b",
					$time, b, k, e, l);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (b !== want.out_byte) report("out_byte", want.out_byte, b);
			if (k !== want.kind) report("result_kind", {6'b0, want.kind}, {6'b0, k});
			if (e !== want.err) report("error_code", {4'b0, want.err}, {4'b0, e});
			if (l !== want.last) report("last", {7'b0, want.last}, {7'b0, l});
			case (want.kind)
				KIND_BYTE:  n_bytes++;
				KIND_CLOSE: n_closes++;
				default: begin
					n_errors++;
					codes_seen[want.err] = 1'b1;
				end
			endcase
		endfunction
	endclass

endpackage

### tb/sv/json_string_unescape_utf8_test.sv
// Top-level test of the JSON string unescaper with random stalls on both channels.
module json_string_unescape_utf8_test;
	import jsu_pkg::*;
	import jsu_decode_board_pkg::*;

	typedef enum int {
		PIECE_PLAIN,
		PIECE_RAW,
		PIECE_ESC,
		PIECE_BMP,
		PIECE_PAIR
	} piece_t;

	typedef enum int {
		END_CLOSE,
		END_EOI_STR,
		END_EOI_ESC,
		END_BAD_ESC,
		END_BAD_HEX,
		END_EOI_HEX,
		END_NO_LOW,
		END_BAD_LOW,
		END_LONE_LOW
	} ending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   steady = 1'b0;
	int   bytes_sent = 0;
	int   strings_opened = 0;

	utf8_decode_board board = new();

	jsu_text_if text_ch();
	jsu_dec_if  dec_ch();

	json_string_unescape_utf8 i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.decoded(dec_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		dec_ch.ready <= steady || ($urandom_range(99) >= 22);
		if (arst_n && dec_ch.valid && dec_ch.ready) begin
			board.check_result(dec_ch.out_byte, dec_ch.result_kind, dec_ch.error_code,
				dec_ch.last);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic e);
		while (!steady && $urandom_range(99) < 22) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.in_byte <= b;
		text_ch.end_of_input <= e;
		do @(posedge clk); while (!text_ch.ready);
		board.note_text(b, e);
		bytes_sent++;
		// run without gaps on either side through the middle of the random part
		steady = (bytes_sent >= 140 && bytes_sent < 230);
	endtask

	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + {4'b0, v};
		return ($urandom_range(1) != 0 ? 8'h61 : 8'h41) + {4'b0, v} - 8'd10;
	endfunction

	task automatic send_hex_digits(input logic [15:0] v, input int n);
		for (int i = 3; i > 3 - n; i--) begin
			send_item(hex_char(v[i*4 +: 4]), 1'b0);
		end
	endtask

	task automatic send_code(input logic [15:0] v);
		send_item(CH_BACKSLASH, 1'b0);
		send_item(CH_U, 1'b0);
		send_hex_digits(v, 4);
	endtask

	task automatic send_high();
		send_code(HIGH_FIRST + 16'($urandom_range(1023)));
	endtask

	function automatic logic [7:0] pick_text_byte(input bit printable);
		logic [7:0] b;
		do begin
			b = printable ? 8'($urandom_range(126, 32)) : 8'($urandom);
		end while (b == CH_QUOTE || b == CH_BACKSLASH);
		return b;
	endfunction

	function automatic logic [7:0] pick_byte_not(input logic [7:0] avoid);
		logic [7:0] b;
		do b = 8'($urandom); while (b == avoid);
		return b;
	endfunction

	function automatic logic [7:0] pick_non_hex();
		logic [7:0] b;
		logic [3:0] v;
		do b = 8'($urandom); while (hex_nibble(b, v));
		return b;
	endfunction

	function automatic logic [7:0] pick_bad_escape();
		logic [7:0] b;
		logic [7:0] v;
		do b = 8'($urandom); while (escape_value(b, v) || b == CH_U);
		return b;
	endfunction

	function automatic logic [15:0] pick_bmp();
		logic [15:0] cp;
		case ($urandom_range(4))
			0: cp = 16'($urandom_range(16'h7F));
			1: cp = 16'($urandom_range(16'h7FF, 16'h80));
			2: cp = 16'($urandom_range(16'hD7FF, 16'h800));
			3: cp = 16'($urandom_range(16'hFFFF, 16'hE000));
			default: begin
				// boundaries of the UTF-8 length classes
				case ($urandom_range(5))
					0: cp = 16'h0000;
					1: cp = 16'h007F;
					2: cp = 16'h0080;
					3: cp = 16'h07FF;
					4: cp = 16'h0800;
					default: cp = 16'hFFFF;
				endcase
			end
		endcase
		return cp;
	endfunction

	task automatic send_random_string();
		int         pieces;
		ending_t    fin;
		logic [7:0] esc_chars [8];
		logic [15:0] cp;
		esc_chars = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
		// stray byte or end of input before the opening quote
		if ($urandom_range(7) == 0) begin
			send_item(pick_byte_not(CH_QUOTE), 1'($urandom_range(1)));
		end
		send_item(CH_QUOTE, 1'b0);
		strings_opened++;
		pieces = $urandom_range(6);
		repeat (pieces) begin
			case (piece_t'($urandom_range(int'(PIECE_PAIR))))
				PIECE_PLAIN: send_item(pick_text_byte(1'b1), 1'b0);
				PIECE_RAW:   send_item(pick_text_byte(1'b0), 1'b0);
				PIECE_ESC: begin
					send_item(CH_BACKSLASH, 1'b0);
					send_item(esc_chars[$urandom_range(7)], 1'b0);
				end
				PIECE_BMP: send_code(pick_bmp());
				default: begin
					send_high();
					send_code(LOW_FIRST + 16'($urandom_range(1023)));
				end
			endcase
		end
		if ($urandom_range(99) < 55) begin
			fin = END_CLOSE;
		end else begin
			fin = ending_t'($urandom_range(int'(END_LONE_LOW), int'(END_EOI_STR)));
		end
		case (fin)
			END_CLOSE:   send_item(CH_QUOTE, 1'b0);
			END_EOI_STR: send_item(8'($urandom), 1'b1);
			END_EOI_ESC: begin
				send_item(CH_BACKSLASH, 1'b0);
				send_item(8'($urandom), 1'b1);
			end
			END_BAD_ESC: begin
				send_item(CH_BACKSLASH, 1'b0);
				send_item(pick_bad_escape(), 1'b0);
			end
			END_BAD_HEX, END_EOI_HEX: begin
				// sometimes break the digits of the low half instead
				if ($urandom_range(1) != 0) send_high();
				send_item(CH_BACKSLASH, 1'b0);
				send_item(CH_U, 1'b0);
				send_hex_digits(16'($urandom), $urandom_range(3));
				if (fin == END_BAD_HEX) send_item(pick_non_hex(), 1'b0);
				else send_item(8'($urandom), 1'b1);
			end
			END_NO_LOW: begin
				send_high();
				case ($urandom_range(3))
					0: send_item(pick_byte_not(CH_BACKSLASH), 1'b0);
					1: send_item(8'($urandom), 1'b1);
					2: begin
						send_item(CH_BACKSLASH, 1'b0);
						send_item(pick_byte_not(CH_U), 1'b0);
					end
					default: begin
						send_item(CH_BACKSLASH, 1'b0);
						send_item(8'($urandom), 1'b1);
					end
				endcase
			end
			END_BAD_LOW: begin
				send_high();
				do cp = 16'($urandom); while (cp >= LOW_FIRST && cp <= LOW_LAST);
				send_code(cp);
			end
			default: send_code(LOW_FIRST + 16'($urandom_range(1023)));
		endcase
	endtask

	initial begin
		text_ch.valid <= 1'b0;
		text_ch.in_byte <= 8'h00;
		text_ch.end_of_input <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no opening quote, by byte and by end of input
		send_item(8'h41, 1'b0);
		send_item(8'h00, 1'b1);
		// raw high byte, \u0000, largest surrogate pair, close
		send_item(CH_QUOTE, 1'b0);
		send_item(8'hFF, 1'b0);
		send_code(16'h0000);
		send_code(HIGH_LAST);
		send_code(LOW_LAST);
		send_item(CH_QUOTE, 1'b0);
		// unknown escape, then end of input inside a string
		send_item(CH_QUOTE, 1'b0);
		send_item(CH_BACKSLASH, 1'b0);
		send_item(8'h71, 1'b0);
		send_item(CH_QUOTE, 1'b0);
		send_item(8'hFF, 1'b1);
		text_ch.valid <= 1'b0;
		wait_drained();

		while (bytes_sent < 320) begin
			send_random_string();
			if ($urandom_range(9) == 0) begin
				text_ch.valid <= 1'b0;
				wait_drained();
			end
		end
		text_ch.valid <= 1'b0;
		wait_drained();
		repeat (12) @(posedge clk);

		$display("Sent %0d text bytes over %0d strings with random gaps and stalls.",
			bytes_sent, strings_opened);
		$display("Checked %0d results: %0d bytes, %0d closes, %0d errors (codes %b).",
			board.checked, board.n_bytes, board.n_closes, board.n_errors,
			board.codes_seen[9:0]);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
